// ----- src/jdr_pkg.sv -----
// package: widths, register indexes and shared types for the joystick rescaler
`default_nettype none
package jdr_pkg;
   localparam int AXIS_BITS = 16;
   localparam int BTN_BITS = 12;
   localparam int HAT_BITS = 17;
   localparam int LANES = 3;
   localparam logic [AXIS_BITS-1:0] AXIS_MAX = '1;
   localparam logic [AXIS_BITS-1:0] AXIS_MID = AXIS_MAX >> 1;
   localparam logic [AXIS_BITS-1:0] HAT_NEUTRAL = 16'hFFFF;

   localparam logic [2:0] REG_X_LOW = 3'd0;
   localparam logic [2:0] REG_X_HIGH = 3'd1;
   localparam logic [2:0] REG_Y_LOW = 3'd2;
   localparam logic [2:0] REG_Y_HIGH = 3'd3;
   localparam logic [2:0] REG_ROT_LOW = 3'd4;
   localparam logic [2:0] REG_ROT_HIGH = 3'd5;
   localparam logic [2:0] REG_MASK = 3'd6;

   localparam logic [1:0] MODE_DEAD = 2'd0;
   localparam logic [1:0] MODE_LOW = 2'd1;
   localparam logic [1:0] MODE_UP = 2'd2;
   localparam logic [1:0] MODE_PASS = 2'd3;

   typedef struct packed {
      logic [AXIS_BITS-1:0] low;
      logic [AXIS_BITS-1:0] high;
      logic scale_up;
   } band_type;
endpackage
`default_nettype wire

// ----- src/jdr_if.sv -----
// valid/ready channel interface carrying one item
`default_nettype none
interface jdr_if #(parameter int W = 1) (input wire logic clock);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/joystick_deadzone_rescaler.sv -----
// top level: three axis lanes, pipelined, with an output register
`default_nettype none
// One report enters per cycle unless the output stalls; it passes one
// multiply stage, 32 one-bit divider stages and one output register.
// Each axis has its own lane of pipelined restoring division; the lanes run
// in lockstep and stall together when the output is not taken. The user
// writes band registers over csr_ while the block is idle; it does not check.
module joystick_deadzone_rescaler import jdr_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [2:0] csr_index,
   input wire logic [AXIS_BITS-1:0] csr_data,
   jdr_if.sink req,
   jdr_if.source rsp
);
   localparam int DEPTH = 2 * AXIS_BITS + 1;
   localparam int IW = 4*AXIS_BITS + BTN_BITS + AXIS_BITS;
   localparam int OW = 4*AXIS_BITS + BTN_BITS + HAT_BITS + 3;
   band_type band_ff [LANES];
   logic [DEPTH-1:0] vld_ff;
   logic [AXIS_BITS-1:0] slider_ff [DEPTH];
   logic [BTN_BITS-1:0] btn_ff [DEPTH];
   logic [AXIS_BITS-1:0] hat_ff [DEPTH];
   logic [AXIS_BITS-1:0] lane_value [LANES];
   logic [LANES-1:0] lane_dead;
   logic [OW-1:0] merged;
   logic out_vld_ff;
   logic [OW-1:0] out_ff;
   logic adv;

   // pipeline moves whenever the output register is free or being emptied
   assign adv = !out_vld_ff || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = out_vld_ff;
   assign rsp.data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff[0] <= '{low: 16'd28671, high: 16'd39129, scale_up: 1'b1};
         band_ff[1] <= '{low: 16'd28605, high: 16'd35599, scale_up: 1'b1};
         band_ff[2] <= '{low: 16'd22189, high: 16'd32768, scale_up: 1'b0};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_X_LOW: band_ff[0].low <= csr_data;
            REG_X_HIGH: band_ff[0].high <= csr_data;
            REG_Y_LOW: band_ff[1].low <= csr_data;
            REG_Y_HIGH: band_ff[1].high <= csr_data;
            REG_ROT_LOW: band_ff[2].low <= csr_data;
            REG_ROT_HIGH: band_ff[2].high <= csr_data;
            REG_MASK: begin
               band_ff[0].scale_up <= csr_data[0];
               band_ff[1].scale_up <= csr_data[1];
               band_ff[2].scale_up <= csr_data[2];
            end
            default: ;
         endcase
      end
   end

   // axis fields sit at the top of the item, x first
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      jdr_lane u_lane (
         .clock(clock), .adv(adv),
         .raw(req.data[IW-(i+1)*AXIS_BITS +: AXIS_BITS]),
         .band(band_ff[i]), .value(lane_value[i]), .dead(lane_dead[i])
      );
   end

   // side fields travel alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         slider_ff[0] <= req.data[BTN_BITS+AXIS_BITS +: AXIS_BITS];
         btn_ff[0] <= req.data[AXIS_BITS +: BTN_BITS];
         hat_ff[0] <= req.data[AXIS_BITS-1:0];
         for (int s = 1; s < DEPTH; s++) begin
            slider_ff[s] <= slider_ff[s-1];
            btn_ff[s] <= btn_ff[s-1];
            hat_ff[s] <= hat_ff[s-1];
         end
      end
   end

   jdr_merge u_merge (
      .lane_value(lane_value), .lane_dead(lane_dead),
      .slider(slider_ff[DEPTH-1]), .buttons(btn_ff[DEPTH-1]),
      .hat(hat_ff[DEPTH-1]), .item(merged)
   );

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= vld_ff[DEPTH-1];
   end
   always_ff @(posedge clock) begin
      if (adv) out_ff <= merged;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result dropped while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready) else $error("stalled with empty output");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff)) else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// ----- src/jdr_lane.sv -----
// one axis lane: band classify, then a pipelined restoring divider
`default_nettype none
module jdr_lane import jdr_pkg::*; (
   input wire logic clock,
   input wire logic adv,
   input wire logic [AXIS_BITS-1:0] raw,
   input wire band_type band,
   output logic [AXIS_BITS-1:0] value,
   output logic dead
);
   localparam int NW = 2 * AXIS_BITS;
   localparam int ST = NW + 1;
   logic [NW-1:0] num_ff [ST];
   logic [AXIS_BITS:0] den_ff [ST];
   logic [AXIS_BITS:0] rem_ff [ST];
   logic [1:0] mode_ff [ST];
   logic [AXIS_BITS-1:0] pass_ff [ST];
   logic [AXIS_BITS-1:0] prod_in;
   logic [1:0] mode_in;
   logic [NW-1:0] qfull;

   always_comb begin
      prod_in = '0;
      if (raw >= band.low && raw <= band.high) mode_in = MODE_DEAD;
      else if (raw < band.low) begin
         mode_in = MODE_LOW;
      end else if (band.scale_up) begin
         mode_in = MODE_UP;
         prod_in = raw - band.high;
      end else mode_in = MODE_PASS;
   end

   // stage 0 registers the multiply; remaining stages are one quotient bit each
   always_ff @(posedge clock) begin
      if (adv) begin
         mode_ff[0] <= mode_in;
         pass_ff[0] <= raw;
         rem_ff[0] <= '0;
         if (mode_in == MODE_LOW) begin
            num_ff[0] <= NW'(raw) * NW'(AXIS_MID);
            den_ff[0] <= {1'b0, band.low};
         end else begin
            num_ff[0] <= NW'(prod_in) * NW'(AXIS_MAX - AXIS_MID);
            den_ff[0] <= {1'b0, AXIS_MAX - band.high};
         end
         for (int s = 1; s < ST; s++) begin
            logic [AXIS_BITS+1:0] t;
            t = {rem_ff[s-1], num_ff[s-1][NW-1]};
            mode_ff[s] <= mode_ff[s-1];
            pass_ff[s] <= pass_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            if (t >= {1'b0, den_ff[s-1]}) begin
               rem_ff[s] <= (AXIS_BITS+1)'(t - {1'b0, den_ff[s-1]});
               num_ff[s] <= {num_ff[s-1][NW-2:0], 1'b1};
            end else begin
               rem_ff[s] <= t[AXIS_BITS:0];
               num_ff[s] <= {num_ff[s-1][NW-2:0], 1'b0};
            end
         end
      end
   end

   assign qfull = num_ff[ST-1];

   always_comb begin
      logic [NW:0] sum;
      sum = {1'b0, qfull} + (NW+1)'(AXIS_MID);
      dead = 1'b0;
      case (mode_ff[ST-1])
         MODE_DEAD: begin
            value = AXIS_MID;
            dead = 1'b1;
         end
         MODE_LOW: value = (qfull > NW'(AXIS_MID)) ? AXIS_MID : qfull[AXIS_BITS-1:0];
         MODE_UP: value = (sum > (NW+1)'(AXIS_MAX)) ? AXIS_MAX : sum[AXIS_BITS-1:0];
         default: value = pass_ff[ST-1];
      endcase
   end
endmodule
`default_nettype wire

// ----- src/jdr_merge.sv -----
// merge stage: gathers lane results with the passed-through fields into one item
`default_nettype none
module jdr_merge import jdr_pkg::*; (
   input wire logic [AXIS_BITS-1:0] lane_value [LANES],
   input wire logic [LANES-1:0] lane_dead,
   input wire logic [AXIS_BITS-1:0] slider,
   input wire logic [BTN_BITS-1:0] buttons,
   input wire logic [AXIS_BITS-1:0] hat,
   output logic [3*AXIS_BITS+AXIS_BITS+BTN_BITS+HAT_BITS+3-1:0] item
);
   logic [HAT_BITS-1:0] hat_out;
   assign hat_out = (hat == HAT_NEUTRAL) ? '1 : {1'b0, hat};
   assign item = {lane_value[0], lane_value[1], lane_value[2], slider, buttons,
                  hat_out, lane_dead};
endmodule
`default_nettype wire
